FILE: rtl/cop_pkg.sv
// ----------------------------------------------------------------------------
// cop_pkg - shared widths, codes and stage types
// Widths and the result codes of the sphere overlap push resolver, plus
// the packed records that travel through its square root and divider rows.
// ----------------------------------------------------------------------------
package cop_pkg;

  localparam int PosW  = 24;            // Q15.8 position
  localparam int RadW  = 16;            // Q8.8 radius
  localparam int DiffW = PosW + 1;      // centre difference / its magnitude
  localparam int SqW   = 2 * DiffW;     // squared distance
  localparam int RootW = SqW / 2;       // distance, one root bit per stage
  localparam int RemW  = RootW + 3;     // root remainder
  localparam int TotW  = RadW + 1;      // radius sum, depth, pushing distance
  localparam int NumW  = 2 * TotW;      // |d| * depth
  localparam int NW    = NumW + 2;      // 2 * num + distance
  localparam int QW    = TotW;          // quotient bits, one per stage
  localparam int DenW  = TotW + 1;      // 2 * distance
  localparam int ExtW  = PosW + 2;      // position plus push before clamping

  localparam logic signed [ExtW-1:0] PosMax = ExtW'(8388607);
  localparam logic signed [ExtW-1:0] PosMin = -ExtW'(8388608);

  localparam logic [1:0] MOVED_NONE   = 2'd0;
  localparam logic [1:0] MOVED_FIRST  = 2'd1;
  localparam logic [1:0] MOVED_SECOND = 2'd2;

  typedef struct packed {
    logic [SqW-1:0]              sum;
    logic [RemW-1:0]             rem;
    logic [RootW-1:0]            root;
    logic                        nz;
    logic [2:0][DiffW-1:0]       mag;
    logic [2:0]                  neg;
    logic [2:0][PosW-1:0]        base;
    logic                        first;
    logic [TotW-1:0]             total;
  } sqrt_stage_t;

  typedef struct packed {
    logic [2:0][DenW-1:0]        rem;
    logic [2:0][QW-1:0]          low;
    logic [2:0][QW-1:0]          q;
    logic [DenW-1:0]             den;
    logic                        push;
    logic [2:0]                  neg;
    logic [2:0][PosW-1:0]        base;
    logic                        first;
  } div_stage_t;

endpackage

FILE: rtl/circle_overlap_push_resolver_top.sv
// ----------------------------------------------------------------------------
// circle_overlap_push_resolver_top - sphere pair overlap push
// Pipelined resolver: distance by a bit-per-stage square root, push scale by
// a bit-per-stage divider, saturated new centre of the smaller body.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive both bodies on the in_* ports and raise start. A
//   beat is taken at every rising edge with start high and busy low. busy
//   is always low, so a new pair may enter every cycle.
//   Result channel: out_valid strobes for one cycle with out_moved_body and
//   out_new_x/y/z. The receiver cannot stall; it must take each beat.
//   Each accepted start yields one out_valid strobe, in order of entry.
//   Throughput: one pair per cycle; the depth is set by the 25 root stages
//   and 17 divider stages, one bit of result each.
//   out_moved_body: 0 no overlap or coincident centres (positions read 0),
//   1 first body pushed, 2 second body pushed (equal radii move the second).
//   Reset (synchronous, rst_n low) clears every valid bit so nothing in
//   flight comes out; payload registers are not cleared.
// ----------------------------------------------------------------------------
module circle_overlap_push_resolver_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [cop_pkg::PosW-1:0]     in_first_x,
  input  logic [cop_pkg::PosW-1:0]     in_first_y,
  input  logic [cop_pkg::PosW-1:0]     in_first_z,
  input  logic [cop_pkg::RadW-1:0]     in_first_radius,
  input  logic [cop_pkg::PosW-1:0]     in_second_x,
  input  logic [cop_pkg::PosW-1:0]     in_second_y,
  input  logic [cop_pkg::PosW-1:0]     in_second_z,
  input  logic [cop_pkg::RadW-1:0]     in_second_radius,
  output logic                         out_valid,
  output logic [1:0]                   out_moved_body,
  output logic [cop_pkg::PosW-1:0]     out_new_x,
  output logic [cop_pkg::PosW-1:0]     out_new_y,
  output logic [cop_pkg::PosW-1:0]     out_new_z
);
  import cop_pkg::*;

  // Never holds off the sender: every stage advances every cycle.
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Stage A: centre difference, pick the body that moves
  // --------------------------------------------------------------------------
  logic [PosW-1:0]         p1 [3];
  logic [PosW-1:0]         p2 [3];
  logic                    a_vld_r;
  logic signed [DiffW-1:0] a_d_r [3];
  logic [PosW-1:0]         a_base_r [3];
  logic                    a_first_r;
  logic [TotW-1:0]         a_total_r;
  logic                    take_first;

  assign p1[0] = in_first_x;
  assign p1[1] = in_first_y;
  assign p1[2] = in_first_z;
  assign p2[0] = in_second_x;
  assign p2[1] = in_second_y;
  assign p2[2] = in_second_z;
  // Strictly smaller first radius moves the first body; a tie moves the second.
  assign take_first = in_first_radius < in_second_radius;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      a_d_r[i]    <= $signed({p2[i][PosW-1], p2[i]}) - $signed({p1[i][PosW-1], p1[i]});
      a_base_r[i] <= take_first ? p1[i] : p2[i];
    end
    a_first_r <= take_first;
    a_total_r <= TotW'(in_first_radius) + TotW'(in_second_radius);
  end

  // --------------------------------------------------------------------------
  // Stage B: per-axis magnitude and square
  // --------------------------------------------------------------------------
  logic [DiffW-1:0] a_mag [3];
  logic [SqW-1:0]   a_sq  [3];
  logic             b_vld_r;
  logic [SqW-1:0]   b_sq_r [3];
  logic [DiffW-1:0] b_mag_r [3];
  logic [2:0]       b_neg_r;
  logic [PosW-1:0]  b_base_r [3];
  logic             b_first_r;
  logic [TotW-1:0]  b_total_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_mag[i] = a_d_r[i][DiffW-1] ? DiffW'(-a_d_r[i]) : DiffW'(a_d_r[i]);
      a_sq[i]  = a_mag[i] * a_mag[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      b_sq_r[i]   <= a_sq[i];
      b_mag_r[i]  <= a_mag[i];
      b_neg_r[i]  <= a_d_r[i][DiffW-1];
      b_base_r[i] <= a_base_r[i];
    end
    b_first_r <= a_first_r;
    b_total_r <= a_total_r;
  end

  // --------------------------------------------------------------------------
  // Stage C: squared distance, seeds the root row (sq_r[0])
  // Root row: one result bit per stage, two radicand bits consumed each.
  // --------------------------------------------------------------------------
  sqrt_stage_t sq_r   [RootW+1];
  logic [RootW:0] sq_vld_r;
  logic [SqW-1:0] b_sum;

  assign b_sum = b_sq_r[0] + b_sq_r[1] + b_sq_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else begin
      sq_vld_r[0] <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_r[0].sum   <= b_sum;
    sq_r[0].rem   <= '0;
    sq_r[0].root  <= '0;
    sq_r[0].nz    <= |b_sum;
    for (int i = 0; i < 3; i++) begin
      sq_r[0].mag[i]  <= b_mag_r[i];
      sq_r[0].neg[i]  <= b_neg_r[i];
      sq_r[0].base[i] <= b_base_r[i];
    end
    sq_r[0].first <= b_first_r;
    sq_r[0].total <= b_total_r;
  end

  for (genvar k = 0; k < RootW; k++) begin : g_root
    localparam int Hi = SqW - 1 - 2 * k;
    logic [RemW-1:0]  sh;
    logic [RemW-1:0]  trial;
    logic             ge;
    sqrt_stage_t      nxt;

    always_comb begin
      sh    = {sq_r[k].rem[RemW-3:0], sq_r[k].sum[Hi -: 2]};
      trial = RemW'({sq_r[k].root, 2'b01});
      ge    = sh >= trial;
      nxt      = sq_r[k];
      nxt.rem  = ge ? sh - trial : sh;
      nxt.root = {sq_r[k].root[RootW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      sq_r[k+1] <= nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: depth and push decision
  // --------------------------------------------------------------------------
  logic [RootW-1:0] root_len;
  logic             e_push;
  logic             e_vld_r;
  logic             e_push_r;
  logic [TotW-1:0]  e_depth_r;
  logic [TotW-1:0]  e_dist_r;
  logic [TotW-1:0]  e_mag_r [3];
  logic [2:0]       e_neg_r;
  logic [PosW-1:0]  e_base_r [3];
  logic             e_first_r;

  assign root_len = sq_r[RootW].root;
  assign e_push   = sq_r[RootW].nz && (RootW'(sq_r[RootW].total) > root_len);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= sq_vld_r[RootW];
    end
  end

  // On a push the distance and each axis magnitude are below the radius sum,
  // so the low bits carry them exactly; otherwise they are don't-care.
  always_ff @(posedge clk) begin
    e_push_r  <= e_push;
    e_depth_r <= sq_r[RootW].total - root_len[TotW-1:0];
    e_dist_r  <= root_len[TotW-1:0];
    for (int i = 0; i < 3; i++) begin
      e_mag_r[i]  <= sq_r[RootW].mag[i][TotW-1:0];
      e_neg_r[i]  <= sq_r[RootW].neg[i] ^ sq_r[RootW].first;
      e_base_r[i] <= sq_r[RootW].base[i];
    end
    e_first_r <= sq_r[RootW].first;
  end

  // --------------------------------------------------------------------------
  // Stage M: |d| * depth per axis
  // --------------------------------------------------------------------------
  logic [NumW-1:0] e_num [3];
  logic            m_vld_r;
  logic            m_push_r;
  logic [NumW-1:0] m_num_r [3];
  logic [TotW-1:0] m_dist_r;
  logic [2:0]      m_neg_r;
  logic [PosW-1:0] m_base_r [3];
  logic            m_first_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_num[i] = e_mag_r[i] * e_depth_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      m_num_r[i]  <= e_num[i];
      m_base_r[i] <= e_base_r[i];
    end
    m_push_r  <= e_push_r;
    m_dist_r  <= e_dist_r;
    m_neg_r   <= e_neg_r;
    m_first_r <= e_first_r;
  end

  // --------------------------------------------------------------------------
  // Divider row: (2*num + distance) / (2*distance), one quotient bit per stage.
  // The quotient never exceeds the depth, so the top bits start below the
  // divisor and the partial remainder fits the divisor width.
  // --------------------------------------------------------------------------
  div_stage_t     dv_r [QW+1];
  logic [QW:0]    dv_vld_r;
  logic [NW-1:0]  m_n [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_n[i] = NW'({m_num_r[i], 1'b0}) + NW'(m_dist_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else begin
      dv_vld_r[0] <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dv_r[0].rem[i]  <= m_n[i][QW+DenW-1:QW];
      dv_r[0].low[i]  <= m_n[i][QW-1:0];
      dv_r[0].q[i]    <= '0;
      dv_r[0].base[i] <= m_base_r[i];
    end
    dv_r[0].den   <= {m_dist_r, 1'b0};
    dv_r[0].push  <= m_push_r;
    dv_r[0].neg   <= m_neg_r;
    dv_r[0].first <= m_first_r;
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int Bit = QW - 1 - j;
    logic [DenW:0] sh [3];
    logic [2:0]    ge;
    div_stage_t    nxt;

    always_comb begin
      nxt = dv_r[j];
      for (int i = 0; i < 3; i++) begin
        sh[i]  = {dv_r[j].rem[i], dv_r[j].low[i][Bit]};
        ge[i]  = sh[i] >= {1'b0, dv_r[j].den};
        nxt.rem[i]    = ge[i] ? DenW'(sh[i] - {1'b0, dv_r[j].den}) : sh[i][DenW-1:0];
        nxt.q[i][Bit] = ge[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j+1] <= 1'b0;
      end else begin
        dv_vld_r[j+1] <= dv_vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      dv_r[j+1] <= nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: apply the push with its direction, clamp to 24 bits
  // --------------------------------------------------------------------------
  logic signed [ExtW-1:0] step [3];
  logic signed [ExtW-1:0] moved [3];
  logic [PosW-1:0]        clamped [3];
  logic                   out_valid_r;
  logic [1:0]             out_moved_r;
  logic [PosW-1:0]        out_pos_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      step[i]  = dv_r[QW].neg[i] ? -$signed(ExtW'(dv_r[QW].q[i]))
                                 :  $signed(ExtW'(dv_r[QW].q[i]));
      moved[i] = $signed({{2{dv_r[QW].base[i][PosW-1]}}, dv_r[QW].base[i]}) + step[i];
      if (moved[i] > PosMax) begin
        clamped[i] = PosMax[PosW-1:0];
      end else if (moved[i] < PosMin) begin
        clamped[i] = PosMin[PosW-1:0];
      end else begin
        clamped[i] = moved[i][PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld_r[QW];
    end
  end

  // Drop the push entirely when the bodies do not overlap.
  always_ff @(posedge clk) begin
    if (dv_r[QW].push) begin
      out_moved_r <= dv_r[QW].first ? MOVED_FIRST : MOVED_SECOND;
      for (int i = 0; i < 3; i++) begin
        out_pos_r[i] <= clamped[i];
      end
    end else begin
      out_moved_r <= MOVED_NONE;
      for (int i = 0; i < 3; i++) begin
        out_pos_r[i] <= '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_moved_body = out_moved_r;
  assign out_new_x      = out_pos_r[0];
  assign out_new_y      = out_pos_r[1];
  assign out_new_z      = out_pos_r[2];

endmodule
